// File: sv/stt_pkg.sv
// ---------------------------------------------------------------------------
// stt_pkg: shared types and constants of the software timer table
// request and result codes, word layouts, cell status
// ---------------------------------------------------------------------------
package stt_pkg;

	localparam int DefaultSlots = 16;
	localparam int MaxResults   = 16;
	localparam int IdW          = 16;
	localparam int TimeW        = 32;

	typedef enum logic [1:0] {
		REQ_CREATE   = 2'd0,
		REQ_KILL     = 2'd1,
		REQ_TICK     = 2'd2,
		REQ_KILL_ALL = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_CREATED = 2'd0,
		KIND_FULL    = 2'd1,
		KIND_FIRED   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [TimeW-1:0] delay_ticks;
		logic [TimeW-1:0] interval_ticks;
		logic [IdW-1:0]   kill_id;
		logic [TimeW-1:0] now_ticks;
	} req_word_t;

	typedef struct packed {
		logic [1:0]     kind;
		logic [IdW-1:0] timer_id;
		logic           last;
	} res_word_t;

	// contents of one slot, handed between neighbors during compaction
	typedef struct packed {
		logic             used;
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] due;
		logic [TimeW-1:0] interval;
		logic             pending;
		logic             dead;
	} slot_t;

	// sequencer controls broadcast to all cells
	typedef struct packed {
		logic             load;      // write new entry into the first free cell
		logic             kill;      // mark first matching cell dead
		logic             kill_all;
		logic             resolve;   // the scanned pending cell gets its due time
		logic             fire;      // the head-of-scan cell fires
		logic             shift;     // compaction step
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] now;
		logic [TimeW-1:0] delay;
		logic [TimeW-1:0] interval;
	} cell_ctl_t;

	function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
			input logic [TimeW-1:0] b);
		logic [TimeW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
	endfunction

endpackage

// File: sv/stt_if.sv
// ---------------------------------------------------------------------------
// stt_if: valid/ready channel
// carries one word of the given type
// ---------------------------------------------------------------------------
interface stt_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/stt_cell.sv
// ---------------------------------------------------------------------------
// stt_cell: one timer slot
// holds an entry, takes the neighbor's entry on a compaction shift
// ---------------------------------------------------------------------------
module stt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stt_pkg::cell_ctl_t    ctl,
	input  logic                  load_sel,   // this cell is the first free one
	input  logic                  kill_sel,   // this cell is the first id match
	input  logic                  fire_sel,   // this cell is under the scan
	input  logic                  shift_sel,  // take the neighbor's entry
	input  stt_pkg::slot_t        nbr,
	output stt_pkg::slot_t        slot
);
	stt_pkg::slot_t slot_q;

	assign slot = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctl.kill_all) begin
			slot_q.used <= 1'b0;
		end else if (ctl.load && load_sel) begin
			slot_q.used     <= 1'b1;
			slot_q.id       <= ctl.id;
			slot_q.due      <= (ctl.delay == '0) ? stt_pkg::TimeW'(1) : ctl.delay;
			slot_q.interval <= ctl.interval;
			slot_q.pending  <= 1'b1;
			slot_q.dead     <= 1'b0;
		end else if (ctl.kill && kill_sel) begin
			slot_q.dead <= 1'b1;
		end else if (ctl.resolve && fire_sel) begin
			if (slot_q.used && !slot_q.dead && slot_q.pending) begin
				slot_q.due     <= stt_pkg::sat_add(ctl.now, slot_q.due);
				slot_q.pending <= 1'b0;
			end
		end else if (ctl.fire && fire_sel) begin
			if (slot_q.interval != '0)
				slot_q.due <= stt_pkg::sat_add(ctl.now, slot_q.interval);
			else
				slot_q.dead <= 1'b1;
		end else if (ctl.shift && shift_sel) begin
			slot_q <= nbr;
		end
	end
endmodule

// File: sv/software_timer_table.sv
// ---------------------------------------------------------------------------
// software_timer_table: compact table of one-shot and periodic timers
// a row of slot cells with a scan sequencer that fires and compacts
// ---------------------------------------------------------------------------
//  channel  dir  word        fields
//  req      in   req_word_t  req_type delay_ticks interval_ticks kill_id now_ticks
//  res      out  res_word_t  kind timer_id last
//
// create passes the decode and result states plus the result handshake;
// kill and kill all pass the decode state only. a tick passes the decode
// state, a scan over every slot (a pending entry gets its due time as the
// scan passes it), a compaction step per removed entry and a closing step.
// the scan walks one cell per cycle; a stalled result holds the scan.
// reset empties all cells and sets the next id to one.
module software_timer_table #(
	parameter int TIMER_SLOTS = stt_pkg::DefaultSlots
) (
	input  logic  clk,
	input  logic  arst_n,
	stt_if.sink   req,
	stt_if.source res
);
	localparam int IW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int RW = $clog2(stt_pkg::MaxResults + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_RESOLVE, ST_SCAN, ST_COMPACT, ST_OUT
	} state_t;

	state_t                 state_q;
	stt_pkg::req_word_t     req_q;
	stt_pkg::res_word_t     res_q;
	logic                   res_valid_q;
	logic [IW-1:0]          scan_q;
	logic [RW-1:0]          fired_q;
	logic [stt_pkg::IdW-1:0] next_id_q;
	logic                   pend_q;     // a fired result waits for its successor
	logic [stt_pkg::IdW-1:0] pend_id_q;

	stt_pkg::slot_t         slot [TIMER_SLOTS];
	stt_pkg::slot_t         nbr  [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] free_v, match_v, keep_v;
	logic [TIMER_SLOTS-1:0] load_sel, kill_sel, fire_sel, shift_sel;
	logic                   full;
	logic                   fire_now;
	logic                   resolve_now;
	logic                   any_dead;
	stt_pkg::cell_ctl_t     ctl;

	always_comb begin
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			free_v[i]  = !slot[i].used;
			match_v[i] = slot[i].used && slot[i].id == req_q.kill_id;
			keep_v[i]  = slot[i].used && !slot[i].dead;
			nbr[i]     = (i == TIMER_SLOTS - 1) ? '0 : slot[(i + 1) % TIMER_SLOTS];
		end
	end

	// first free and first match: priority picks; shift covers the first dead cell and all after it
	always_comb begin
		logic seen_f, seen_m, seen_d;
		seen_f = 1'b0;
		seen_m = 1'b0;
		seen_d = 1'b0;
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			load_sel[i]  = free_v[i] && !seen_f;
			kill_sel[i]  = match_v[i] && !seen_m;
			seen_f       = seen_f | free_v[i];
			seen_m       = seen_m | match_v[i];
			seen_d       = seen_d | (slot[i].used && slot[i].dead);
			shift_sel[i] = seen_d;
		end
		full     = !seen_f;
		any_dead = seen_d;
	end

	always_comb begin
		fire_sel = '0;
		fire_sel[scan_q] = 1'b1;
	end

	// a pending entry only gets its due time on this tick and never fires on it
	assign resolve_now = state_q == ST_SCAN && keep_v[scan_q] && slot[scan_q].pending
		&& !(pend_q && res_valid_q);

	assign fire_now = state_q == ST_SCAN && keep_v[scan_q] && !slot[scan_q].pending
		&& req_q.now_ticks >= slot[scan_q].due && fired_q < RW'(stt_pkg::MaxResults)
		&& !(pend_q && res_valid_q);

	always_comb begin
		ctl          = '0;
		ctl.id       = (state_q == ST_IDLE) ? next_id_q : req_q.kill_id;
		ctl.now      = req_q.now_ticks;
		ctl.delay    = req_q.delay_ticks;
		ctl.interval = req_q.interval_ticks;
		ctl.id       = next_id_q;
		if (state_q == ST_RESOLVE) begin
			case (stt_pkg::req_t'(req_q.req_type))
				stt_pkg::REQ_CREATE:   ctl.load = !full;
				stt_pkg::REQ_KILL:     begin
					ctl.kill = req_q.kill_id != '0;
					ctl.id   = req_q.kill_id;
				end
				stt_pkg::REQ_KILL_ALL: ctl.kill_all = 1'b1;
				default:               ;
			endcase
		end
		ctl.resolve = resolve_now;
		ctl.fire    = fire_now;
		ctl.shift   = state_q == ST_COMPACT;
	end

	for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
		stt_cell u_cell (
			.clk,
			.arst_n,
			.ctl,
			.load_sel  (load_sel[g]),
			.kill_sel  (kill_sel[g]),
			.fire_sel  (fire_sel[g]),
			.shift_sel (shift_sel[g]),
			.nbr       (nbr[g]),
			.slot      (slot[g])
		);
	end

	assign req.ready = state_q == ST_IDLE;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			scan_q      <= '0;
			fired_q     <= '0;
			next_id_q   <= stt_pkg::IdW'(1);
			pend_q      <= 1'b0;
		end else begin
			if (res.valid && res.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						req_q   <= req.data;
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					scan_q  <= '0;
					fired_q <= '0;
					pend_q  <= 1'b0;
					case (stt_pkg::req_t'(req_q.req_type))
						stt_pkg::REQ_CREATE: begin
							res_valid_q    <= 1'b1;
							res_q.last     <= 1'b1;
							if (full) begin
								res_q.kind     <= stt_pkg::KIND_FULL;
								res_q.timer_id <= '0;
							end else begin
								res_q.kind     <= stt_pkg::KIND_CREATED;
								res_q.timer_id <= next_id_q;
								next_id_q      <= (next_id_q == '1) ? stt_pkg::IdW'(1)
									: next_id_q + stt_pkg::IdW'(1);
							end
							state_q <= ST_OUT;
						end
						stt_pkg::REQ_TICK: state_q <= ST_SCAN;
						default:           state_q <= ST_IDLE;
					endcase
				end
				ST_SCAN: begin
					if (!(pend_q && res_valid_q)) begin
						if (fire_now) begin
							// the previous fired id goes out now, not last
							if (pend_q) begin
								res_valid_q    <= 1'b1;
								res_q.kind     <= stt_pkg::KIND_FIRED;
								res_q.timer_id <= pend_id_q;
								res_q.last     <= 1'b0;
							end
							pend_q    <= 1'b1;
							pend_id_q <= slot[scan_q].id;
							fired_q   <= fired_q + RW'(1);
						end
						if (scan_q == IW'(TIMER_SLOTS - 1))
							state_q <= ST_COMPACT;
						else
							scan_q <= scan_q + IW'(1);
					end
				end
				ST_COMPACT: begin
					if (!any_dead && !(pend_q && res_valid_q)) begin
						if (pend_q) begin
							res_valid_q    <= 1'b1;
							res_q.kind     <= stt_pkg::KIND_FIRED;
							res_q.timer_id <= pend_id_q;
							res_q.last     <= 1'b1;
							pend_q         <= 1'b0;
							state_q        <= ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (!res_valid_q || res.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	ap_fired_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fired_q <= RW'(stt_pkg::MaxResults))
		else $error("more fired results than allowed");
	ap_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && state_q == ST_IDLE |-> res_q.last)
		else $error("idle with a non-final result outstanding");
	ap_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("next id reached zero");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.data))
		else $error("result dropped while stalled");
`endif
endmodule

// File: bench/software_timer_table_tb.sv
// ---------------------------------------------------------------------------
// software_timer_table_tb: self-checking bench for the software timer table
// a queue-fed driver offers request words with random gaps, a monitor takes
// result words under random back-pressure and compares them field by field
// with the results that a cycle-free model of the timer table works out
// ---------------------------------------------------------------------------
module software_timer_table_tb;

	localparam int Slots      = stt_pkg::DefaultSlots;
	localparam int IdW        = stt_pkg::IdW;
	localparam int TimeW      = stt_pkg::TimeW;
	localparam int CycleLimit = 2000000;
	localparam int HoldCycles = 400;

	logic clk;
	logic arst_n;

	stt_if #(.word_t(stt_pkg::req_word_t)) req_ch ();
	stt_if #(.word_t(stt_pkg::res_word_t)) res_ch ();

	software_timer_table #(.TIMER_SLOTS(Slots)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.res    (res_ch.source)
	);

	// timer table as seen from outside
	logic [IdW-1:0]   tbl_id [Slots];
	logic [TimeW-1:0] tbl_due [Slots];
	logic [TimeW-1:0] tbl_ivl [Slots];
	bit               tbl_pend [Slots];
	bit               tbl_dead [Slots];
	int               tbl_count;
	logic [IdW-1:0]   tbl_next_id;

	stt_pkg::req_word_t pend_q[$];
	stt_pkg::res_word_t exp_q[$];

	int  n_words;
	int  n_checked;
	int  n_errors;
	int  cycles;
	int  sgap;
	int  rgap;
	int  hold_cnt;
	bit  hold_on;
	bit  hold_start;
	bit  brisk;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [TimeW-1:0] due_sum(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
		logic [TimeW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
	endfunction

	function automatic int draw_wait();
		return brisk ? 0 : int'($urandom_range(0, 9));
	endfunction

	function automatic void queue_req(stt_pkg::req_word_t w);
		pend_q.insert(pend_q.size(), w);
	endfunction

	task automatic timer_reset();
		for (int i = 0; i < Slots; i++) begin
			tbl_id[i] = '0; tbl_due[i] = '0; tbl_ivl[i] = '0;
			tbl_pend[i] = 0; tbl_dead[i] = 0;
		end
		tbl_count   = 0;
		tbl_next_id = 1;
	endtask

	// work out the result words that one request word causes
	task automatic timer_apply(stt_pkg::req_word_t w);
		stt_pkg::res_word_t r;
		int                 n;
		int                 k;
		n = 0;
		case (stt_pkg::req_t'(w.req_type))
			stt_pkg::REQ_CREATE: begin
				if (tbl_count >= Slots) begin
					r.kind = stt_pkg::KIND_FULL; r.timer_id = '0; r.last = 1'b1;
				end else begin
					tbl_id[tbl_count]   = tbl_next_id;
					tbl_due[tbl_count]  = (w.delay_ticks == 0) ? 1 : w.delay_ticks;
					tbl_ivl[tbl_count]  = w.interval_ticks;
					tbl_pend[tbl_count] = 1;
					tbl_dead[tbl_count] = 0;
					tbl_count++;
					r.kind = stt_pkg::KIND_CREATED; r.timer_id = tbl_next_id; r.last = 1'b1;
					tbl_next_id = (tbl_next_id == 16'hFFFF) ? 16'd1 : tbl_next_id + 16'd1;
				end
				exp_q.insert(exp_q.size(), r);
			end
			stt_pkg::REQ_KILL: begin
				if (w.kill_id != 0)
					for (int i = 0; i < tbl_count; i++)
						if (tbl_id[i] == w.kill_id) begin
							tbl_dead[i] = 1;
							break;
						end
			end
			stt_pkg::REQ_KILL_ALL: tbl_count = 0;
			default: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_dead[i])
						continue;
					if (tbl_pend[i]) begin
						// first tick only fixes the due time
						tbl_due[i]  = due_sum(w.now_ticks, tbl_due[i]);
						tbl_pend[i] = 0;
						continue;
					end
					if (w.now_ticks < tbl_due[i] || n >= stt_pkg::MaxResults)
						continue;
					r.kind = stt_pkg::KIND_FIRED; r.timer_id = tbl_id[i]; r.last = 1'b0;
					exp_q.insert(exp_q.size(), r);
					n++;
					if (tbl_ivl[i] != 0)
						tbl_due[i] = due_sum(w.now_ticks, tbl_ivl[i]);
					else
						tbl_dead[i] = 1;
				end
				if (n > 0)
					exp_q[exp_q.size() - 1].last = 1'b1;
				k = 0;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_dead[i])
						continue;
					tbl_id[k] = tbl_id[i]; tbl_due[k] = tbl_due[i];
					tbl_ivl[k] = tbl_ivl[i]; tbl_pend[k] = tbl_pend[i];
					tbl_dead[k] = 0;
					k++;
				end
				tbl_count = k;
			end
		endcase
	endtask

	task automatic report(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		n_errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
			sgap         <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				timer_apply(req_ch.data);
				n_words++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (sgap > 0) begin
					sgap         <= sgap - 1;
					req_ch.valid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= pend_q.pop_front();
					sgap         <= draw_wait();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		stt_pkg::res_word_t w;
		int                 d;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rgap         <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (exp_q.size() == 0) begin
					report("unexpected word, timer_id", res_ch.data.timer_id, 0);
				end else begin
					w = exp_q.pop_front();
					n_checked++;
					if (res_ch.data.kind != w.kind)
						report("kind", res_ch.data.kind, w.kind);
					if (res_ch.data.timer_id != w.timer_id)
						report("timer_id", res_ch.data.timer_id, w.timer_id);
					if (res_ch.data.last != w.last)
						report("last", res_ch.data.last, w.last);
				end
				d = draw_wait();
				rgap         <= d;
				res_ch.ready <= (d == 0) && !hold_on;
			end else if (rgap > 0) begin
				rgap         <= rgap - 1;
				res_ch.ready <= (rgap == 1) && !hold_on;
			end else begin
				res_ch.ready <= !hold_on;
			end
		end
	end

	// long receiver stall, once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_on  <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_start && hold_cnt < HoldCycles) begin
			hold_on  <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else begin
			hold_on <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic stt_pkg::req_word_t mk(stt_pkg::req_t t, logic [TimeW-1:0] dly,
			logic [TimeW-1:0] ivl, logic [IdW-1:0] kid, logic [TimeW-1:0] now);
		stt_pkg::req_word_t w;
		w.req_type = t; w.delay_ticks = dly; w.interval_ticks = ivl;
		w.kill_id = kid; w.now_ticks = now;
		return w;
	endfunction

	task automatic settle();
		while (pend_q.size() > 0 || req_ch.valid || exp_q.size() > 0)
			@(posedge clk);
		// ticks and kills that give no word may still be running
		repeat (2 * Slots + 10) @(posedge clk);
		#1;
	endtask

	logic [TimeW-1:0] cur_now;
	int               pick;
	logic [TimeW-1:0] dly;
	logic [TimeW-1:0] ivl;

	initial begin
		timer_reset();
		n_words = 0; n_checked = 0; n_errors = 0; cycles = 0;
		hold_start = 0; brisk = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		#1 arst_n = 1'b1;

		// zero delay, saturating sums, one-shot and periodic, kills, full table
		queue_req(mk(stt_pkg::REQ_CREATE, 0, 0, 0, 0));
		queue_req(mk(stt_pkg::REQ_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
		queue_req(mk(stt_pkg::REQ_CREATE, 5, 3, 0, 0));
		queue_req(mk(stt_pkg::REQ_TICK, 0, 0, 0, 0));
		queue_req(mk(stt_pkg::REQ_TICK, 0, 0, 0, 1));
		queue_req(mk(stt_pkg::REQ_TICK, 0, 0, 0, 5));
		queue_req(mk(stt_pkg::REQ_TICK, 0, 0, 0, 32'hFFFF_FFFF));
		queue_req(mk(stt_pkg::REQ_KILL, 0, 0, 0, 0));
		queue_req(mk(stt_pkg::REQ_KILL, 0, 0, 16'hFFFF, 0));
		queue_req(mk(stt_pkg::REQ_KILL, 0, 0, 3, 0));
		queue_req(mk(stt_pkg::REQ_TICK, 0, 0, 0, 32'hFFFF_FFFF));
		queue_req(mk(stt_pkg::REQ_KILL_ALL, 0, 0, 0, 0));
		for (int i = 0; i < Slots + 1; i++)
			queue_req(mk(stt_pkg::REQ_CREATE, 1, (i % 2) ? 7 : 0, 0, 0));
		queue_req(mk(stt_pkg::REQ_TICK, 0, 0, 0, 100));
		queue_req(mk(stt_pkg::REQ_TICK, 0, 0, 0, 200));
		queue_req(mk(stt_pkg::REQ_KILL_ALL, 0, 0, 0, 0));
		settle();

		// mostly well-formed traffic with a moving clock, plus noise
		cur_now = 0;
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 1)
				hold_start = 1;
			brisk = (ph == 2);
			for (int i = 0; i < 100; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					dly = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20);
					case ($urandom_range(0, 3))
						0, 1: ivl = 0;
						2: ivl = $urandom_range(1, 15);
						default: ivl = $urandom;
					endcase
					queue_req(mk(stt_pkg::REQ_CREATE, dly, ivl, 0, 0));
				end else if (pick < 75) begin
					if ($urandom_range(0, 19) == 0)
						cur_now = $urandom;
					else
						cur_now = cur_now + $urandom_range(0, 8);
					queue_req(mk(stt_pkg::REQ_TICK, 0, 0, 0, cur_now));
				end else if (pick < 90) begin
					queue_req(mk(stt_pkg::REQ_KILL, 0, 0,
						tbl_next_id - 16'($urandom_range(0, 24)), 0));
				end else if (pick < 95) begin
					queue_req(mk(stt_pkg::REQ_KILL_ALL, 0, 0, 0, 0));
				end else begin
					queue_req(mk(stt_pkg::req_t'($urandom_range(0, 3)), $urandom,
						$urandom, 16'($urandom), $urandom));
				end
			end
			settle();
		end

		$display("covered %0d request words and %0d result words, including",
			n_words, n_checked);
		$display("a full table, saturated due times and a long result stall");
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
